FILE: rtl/prl_pkg.sv
// prl_pkg: shared types and constants of the page replacement unit.
// No dependencies; used by the interfaces, the frame cell and the top level.
package prl_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'd1;

  // replacement modes
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // field widths fixed by the result format
  localparam int FIM_W      = 5;
  localparam int FAULT_W    = 32;
  localparam int EV_PAGE_W  = 16;

  localparam logic [FIM_W-1:0]   FIM_RESET = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 32'hFFFF_FFFF;

  // per-reference decisions broadcast to every frame cell
  typedef struct packed {
    logic clear;   // first reference: table counts as empty
    logic lru;     // recency ordering active
    logic miss;    // page not resident
    logic full;    // resident count at or above frame limit
  } cell_ctrl_t;

  // flags rippling down the row of cells
  typedef struct packed {
    logic found;      // some earlier cell holds the page
    logic free_seen;  // some earlier cell is free
  } chain_t;

endpackage

FILE: rtl/prl_ifs.sv
// prl_ifs: valid/ready channel interfaces of the page replacement unit.
// Depends on prl_pkg for field widths.
interface prl_ref_if #(parameter int PAGE_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;
  logic                 first_reference;
  modport source (output valid, page_number, first_reference, input ready);
  modport sink   (input valid, page_number, first_reference, output ready);
endinterface

interface prl_res_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic                               evicted_valid;
  logic [prl_pkg::EV_PAGE_W-1:0]      evicted_page;
  logic [prl_pkg::FAULT_W-1:0]        fault_total;
  modport source (output valid, hit, evicted_valid, evicted_page, fault_total, input ready);
  modport sink   (input valid, hit, evicted_valid, evicted_page, fault_total, output ready);
endinterface

interface prl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prl_pkg::CFG_IDX_W-1:0]   index;
  logic [prl_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/prl_cell.sv
// prl_cell: one frame of the associative table (page, valid bit, age rank).
// Depends on prl_pkg for the control and chain structs.
module prl_cell #(
  parameter int PAGE_BITS = 16,
  parameter int RW        = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  prl_pkg::cell_ctrl_t   ctrl,
  input  logic [PAGE_BITS-1:0]  req_page,
  input  logic [RW-1:0]         hit_rank,
  input  logic [RW-1:0]         victim_rank,
  input  prl_pkg::chain_t       chain_in,
  output prl_pkg::chain_t       chain_out,
  input  logic [RW-1:0]         rank_in,
  output logic [RW-1:0]         rank_out,
  input  logic [PAGE_BITS-1:0]  evict_in,
  output logic [PAGE_BITS-1:0]  evict_out,
  output logic                  occupied
);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic [RW-1:0]        rank;

  logic          eff_valid, match, victim, tgt;
  logic [RW-1:0] rank_next;

  assign eff_valid = valid & ~ctrl.clear;
  assign match     = eff_valid & (page == req_page);
  assign victim    = eff_valid & ctrl.full & (rank == victim_rank);
  // load target: the victim when full, else the first free frame in the row
  assign tgt = ctrl.miss & (ctrl.full ? victim : (~eff_valid & ~chain_in.free_seen));

  assign chain_out.found     = chain_in.found | match;
  assign chain_out.free_seen = chain_in.free_seen | ~eff_valid;
  assign rank_out  = rank_in | (match ? rank : '0);
  assign evict_out = evict_in | (victim ? page : '0);
  assign occupied  = valid;

  always_comb begin
    priority if (tgt) begin
      rank_next = '0;
    end else if (ctrl.miss && eff_valid) begin
      rank_next = rank + RW'(1);
    end else if (!ctrl.miss && ctrl.lru && match) begin
      rank_next = '0;
    end else if (!ctrl.miss && ctrl.lru && eff_valid && (rank < hit_rank)) begin
      rank_next = rank + RW'(1);
    end else begin
      rank_next = rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (en) begin
      valid <= tgt | eff_valid;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tgt) begin
      page <= req_page;
    end
  end

endmodule

FILE: rtl/page_replacement_fifo_lru_unit.sv
// page_replacement_fifo_lru_unit: top level of the FIFO/LRU page replacement unit.
// Depends on prl_pkg, prl_ifs (channel interfaces) and prl_cell (frame cells).
// The result of an accepted reference transfer is registered in the output register.
// Throughput: one reference per cycle while the result slot is empty or draining; the lookup
//   and rank update ripple combinationally through the row of FRAME_SLOTS frame cells.
// Reset (synchronous, rst high): all frames empty, ranks and fault count zero,
//   FIFO mode, frame limit 16, no result pending. Page storage is not cleared.
module page_replacement_fifo_lru_unit #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  prl_cfg_if.sink       cfg,
  prl_ref_if.sink       refs,
  prl_res_if.source     results
);

  // rank width, resident count width, and a compare width wide enough for the limit
  localparam int RW  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CW  = $clog2(FRAME_SLOTS + 1);
  localparam int LW  = (CW > prl_pkg::FIM_W) ? CW : prl_pkg::FIM_W;
  localparam int EVW = prl_pkg::EV_PAGE_W;
  localparam int FW  = prl_pkg::FAULT_W;

  // ---------------------------------------------------------------
  // Configuration registers; writes are always taken.
  // ---------------------------------------------------------------
  logic                      mode;
  logic [prl_pkg::FIM_W-1:0] fim;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= prl_pkg::MODE_FIFO;
      fim  <= prl_pkg::FIM_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        prl_pkg::CFG_MODE:   mode <= cfg.data[0];
        prl_pkg::CFG_FRAMES: fim  <= cfg.data[prl_pkg::FIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake: the output register decouples the two sides, so a new
  // reference is taken whenever the result slot is empty or draining.
  // ---------------------------------------------------------------
  logic accept;
  logic out_valid;

  assign refs.ready = ~out_valid | results.ready;
  assign accept     = refs.valid & refs.ready;

  // ---------------------------------------------------------------
  // Global bookkeeping: resident count and fault count. A first
  // reference makes both read as zero for this transfer.
  // ---------------------------------------------------------------
  logic [CW-1:0] cnt, cnt_next, used_eff;
  logic [FW-1:0] fc, fc_base, fc_next;
  logic [LW-1:0] lim_raw, lim;
  logic          clear, miss, full;

  assign clear    = refs.first_reference;
  assign used_eff = clear ? '0 : cnt;
  assign fc_base  = clear ? '0 : fc;

  // frame limit: zero acts as one, above the table size saturates
  assign lim_raw = LW'(fim);
  always_comb begin
    priority if (lim_raw == '0) begin
      lim = LW'(1);
    end else if (lim_raw > LW'(FRAME_SLOTS)) begin
      lim = LW'(FRAME_SLOTS);
    end else begin
      lim = lim_raw;
    end
  end

  assign full = LW'(used_eff) >= lim;

  // ---------------------------------------------------------------
  // Row of frame cells. The found flag, the first-free flag, the hit
  // rank and the victim page ripple from cell 0 to the last cell; the
  // decisions made from the end of the row are broadcast back.
  // Ranks of resident frames are always 0..count-1, so the victim is
  // the resident frame whose rank equals count-1.
  // ---------------------------------------------------------------
  prl_pkg::chain_t     chain [FRAME_SLOTS+1];
  logic [RW-1:0]       rank_ch [FRAME_SLOTS+1];
  logic [PAGE_BITS-1:0] evict_ch [FRAME_SLOTS+1];
  logic [FRAME_SLOTS-1:0] occ;

  prl_pkg::cell_ctrl_t ctrl;
  logic [RW-1:0]       victim_rank;

  assign chain[0].found     = 1'b0;
  assign chain[0].free_seen = 1'b0;
  assign rank_ch[0]         = '0;
  assign evict_ch[0]        = '0;

  assign miss        = ~chain[FRAME_SLOTS].found;
  assign victim_rank = RW'(used_eff - CW'(1));

  assign ctrl.clear = clear;
  assign ctrl.lru   = (mode == prl_pkg::MODE_LRU);
  assign ctrl.miss  = miss;
  assign ctrl.full  = full;

  for (genvar g = 0; g < FRAME_SLOTS; g++) begin : g_cell
    prl_cell #(
      .PAGE_BITS (PAGE_BITS),
      .RW        (RW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (accept),
      .ctrl        (ctrl),
      .req_page    (refs.page_number),
      .hit_rank    (rank_ch[FRAME_SLOTS]),
      .victim_rank (victim_rank),
      .chain_in    (chain[g]),
      .chain_out   (chain[g+1]),
      .rank_in     (rank_ch[g]),
      .rank_out    (rank_ch[g+1]),
      .evict_in    (evict_ch[g]),
      .evict_out   (evict_ch[g+1]),
      .occupied    (occ[g])
    );
  end

  // count grows only on a miss with a free frame; fault count saturates
  assign cnt_next = (miss && !full) ? used_eff + CW'(1) : used_eff;
  assign fc_next  = (miss && (fc_base != prl_pkg::FAULT_MAX)) ? fc_base + FW'(1) : fc_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      fc  <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
      fc  <= fc_next;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic           res_hit, res_ev_valid;
  logic [EVW-1:0] res_ev_page;
  logic [FW-1:0]  res_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit      <= ~miss;
      res_ev_valid <= miss & full;
      res_ev_page  <= (miss && full) ? EVW'(evict_ch[FRAME_SLOTS]) : '0;
      res_fault    <= fc_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.hit           = res_hit;
  assign results.evicted_valid = res_ev_valid;
  assign results.evicted_page  = res_ev_page;
  assign results.fault_total   = res_fault;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // resident count tracks the valid bits held in the cells
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == int'(cnt))
    else $error("resident count differs from valid frames");

  // count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(FRAME_SLOTS))
    else $error("resident count above table size");

  // an eviction is only reported with a fault
  a_evict_on_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res_hit && res_ev_valid))
    else $error("eviction reported on a hit");

  // a hit without clear leaves the fault count unchanged
  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !clear && !miss) |=> (fc == $past(fc)) && (res_fault == $past(fc)))
    else $error("fault count moved on a hit");

  // an accepted reference always leaves a pending result
  a_result_pending: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted reference lost its result");

endmodule
